// ===== rtl/rac_pkg.sv =====
// Shared types and constants for the region average colour block.
`default_nettype none
package rac_pkg;

    localparam logic [12:0] SCREEN_WIDTH  = 13'd1920;
    localparam logic [12:0] SCREEN_HEIGHT = 13'd1080;
    localparam logic [24:0] COUNT_LIMIT   = 25'd16777216;

    // Configuration register indexes
    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_RIGHT  = 2'd1;
    localparam logic [1:0] REG_TOP    = 2'd2;
    localparam logic [1:0] REG_BOTTOM = 2'd3;

    // Colour channel that the divider is working on
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef struct packed {
        logic [11:0] left;
        logic [11:0] right;
        logic [11:0] top;
        logic [11:0] bottom;
    } t_region;

    typedef struct packed {
        logic pixel_en;
        logic clear;
    } t_acc_ctrl;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [24:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic       done;
        logic [7:0] quotient;
    } t_div_rsp;

endpackage
`default_nettype wire

// ===== rtl/region_average_colour.sv =====
// Top level: APB registers, frame-end sequencer and output register.
// Pixels enter one per cycle while the input is ready and are summed at once when inside the rectangle.
// The item flagged with tlast (frame end) is summed too, after which the input
// stays not ready while one shared restoring divider, one quotient bit a cycle,
// runs for red, green and blue in turn: the result becomes valid and the input
// is ready again in the same cycle, once the result register is free on the
// downstream side.
// An earlier result may still sit in the output register while new pixels flow.
`default_nettype none
module region_average_colour (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // APB configuration port
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [3:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output logic [31:0]      o_prdata,
    output logic             o_pready,
    // Pixel input
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [11:0] pixel_x, [23:12] pixel_y, [31:24] blue, [39:32] green, [47:40] red
    input  wire logic [47:0] i_s_axis_tdata,
    input  wire logic        i_s_axis_tlast,   // frame_end
    // Result output
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [23:0] average_colour, [48:24] pixels_counted
    output logic [55:0]      o_m_axis_tdata
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_HOLD = 3'b100
    } t_state;

    t_state             r_state, n_state;
    rac_pkg::t_region   r_region;
    logic [1:0]         r_chan, n_chan;
    logic               r_kick, n_kick;
    logic [7:0]         r_mean_red, r_mean_green;
    logic               r_out_valid;
    logic [23:0]        r_out_colour;
    logic [24:0]        r_out_count;

    logic               w_in_acc;
    logic               w_cfg_wr;
    logic               w_load;
    logic               w_out_free;
    logic [31:0]        w_sum_red, w_sum_green, w_sum_blue;
    logic [24:0]        w_count;
    rac_pkg::t_acc_ctrl w_acc_ctrl;
    rac_pkg::t_div_req  w_div_req;
    rac_pkg::t_div_rsp  w_div_rsp;

    // ---------------- configuration ----------------
    assign o_pready = 1'b1;
    assign w_cfg_wr = i_psel && i_penable && i_pwrite && o_pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region <= '0;
        end else if (w_cfg_wr) begin
            unique case (i_paddr[3:2])
                rac_pkg::REG_LEFT:   r_region.left   <= i_pwdata[11:0];
                rac_pkg::REG_RIGHT:  r_region.right  <= i_pwdata[11:0];
                rac_pkg::REG_TOP:    r_region.top    <= i_pwdata[11:0];
                rac_pkg::REG_BOTTOM: r_region.bottom <= i_pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (i_paddr[3:2])
            rac_pkg::REG_LEFT:   o_prdata = {20'd0, r_region.left};
            rac_pkg::REG_RIGHT:  o_prdata = {20'd0, r_region.right};
            rac_pkg::REG_TOP:    o_prdata = {20'd0, r_region.top};
            rac_pkg::REG_BOTTOM: o_prdata = {20'd0, r_region.bottom};
            default:             o_prdata = '0;
        endcase
    end

    // ---------------- datapath ----------------
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    assign w_acc_ctrl.pixel_en = w_in_acc;
    assign w_acc_ctrl.clear    = w_load;

    rac_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_acc_ctrl),
        .i_region    (r_region),
        .i_pixel_x   (i_s_axis_tdata[11:0]),
        .i_pixel_y   (i_s_axis_tdata[23:12]),
        .i_blue      (i_s_axis_tdata[31:24]),
        .i_green     (i_s_axis_tdata[39:32]),
        .i_red       (i_s_axis_tdata[47:40]),
        .o_sum_red   (w_sum_red),
        .o_sum_green (w_sum_green),
        .o_sum_blue  (w_sum_blue),
        .o_count     (w_count)
    );

    always_comb begin
        w_div_req.start   = r_kick;
        w_div_req.divisor = w_count;
        unique case (r_chan)
            rac_pkg::CH_RED:   w_div_req.dividend = w_sum_red;
            rac_pkg::CH_GREEN: w_div_req.dividend = w_sum_green;
            rac_pkg::CH_BLUE:  w_div_req.dividend = w_sum_blue;
            default:           w_div_req.dividend = '0;
        endcase
    end

    rac_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        n_chan  = r_chan;
        n_kick  = 1'b0;
        w_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_s_axis_tlast) begin
                    n_state = S_DIV;
                    n_chan  = rac_pkg::CH_RED;
                    n_kick  = 1'b1;
                end
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    if (r_chan == rac_pkg::CH_BLUE) begin
                        if (w_out_free) begin
                            w_load  = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_HOLD;
                        end
                    end else begin
                        n_chan = r_chan + 2'd1;
                        n_kick = 1'b1;
                    end
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_chan  <= rac_pkg::CH_RED;
            r_kick  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_chan  <= n_chan;
            r_kick  <= n_kick;
        end
    end

    // Capture each channel mean as the divider finishes it
    always_ff @(posedge i_clk) begin
        if (w_div_rsp.done && r_state == S_DIV) begin
            if (r_chan == rac_pkg::CH_RED) begin
                r_mean_red <= w_div_rsp.quotient;
            end
            if (r_chan == rac_pkg::CH_GREEN) begin
                r_mean_green <= w_div_rsp.quotient;
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Blue quotient stays in the divider until the next start
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_count  <= w_count;
            r_out_colour <= (w_count == '0) ? 24'd0 :
                            {r_mean_red, r_mean_green, w_div_rsp.quotient};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_count, r_out_colour};

    // ---------------- assertions ----------------
    a_frame_end_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_s_axis_tlast |=> r_state == S_DIV && r_kick)
        else $error("frame end did not start the divide sequence");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> r_state == S_DIV)
        else $error("divider finished outside the divide state");

    a_empty_is_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_count == '0 |-> r_out_colour == '0)
        else $error("empty region gave a nonzero colour");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= rac_pkg::COUNT_LIMIT)
        else $error("pixel count passed its limit");

    a_clear_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> w_count == '0 && w_sum_red == '0)
        else $error("sums not cleared after result");

endmodule
`default_nettype wire

// ===== rtl/rac_accum.sv =====
// Rectangle test and colour sum / pixel count accumulators.
`default_nettype none
module rac_accum (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire rac_pkg::t_acc_ctrl i_ctrl,
    input  wire rac_pkg::t_region   i_region,
    input  wire logic [11:0]        i_pixel_x,
    input  wire logic [11:0]        i_pixel_y,
    input  wire logic [7:0]         i_blue,
    input  wire logic [7:0]         i_green,
    input  wire logic [7:0]         i_red,
    output logic [31:0]             o_sum_red,
    output logic [31:0]             o_sum_green,
    output logic [31:0]             o_sum_blue,
    output logic [24:0]             o_count
);

    logic [31:0] r_sum_red, r_sum_green, r_sum_blue;
    logic [24:0] r_count;
    logic [12:0] w_right;
    logic [12:0] w_bottom;
    logic        w_inside;

    // Clamp the exclusive bounds to the last column / row of the screen
    always_comb begin
        w_right  = ({1'b0, i_region.right} >= rac_pkg::SCREEN_WIDTH) ?
                   rac_pkg::SCREEN_WIDTH - 13'd1 : {1'b0, i_region.right};
        w_bottom = ({1'b0, i_region.bottom} >= rac_pkg::SCREEN_HEIGHT) ?
                   rac_pkg::SCREEN_HEIGHT - 13'd1 : {1'b0, i_region.bottom};
        w_inside = (i_pixel_x >= i_region.left) && ({1'b0, i_pixel_x} < w_right) &&
                   (i_pixel_y >= i_region.top) && ({1'b0, i_pixel_y} < w_bottom) &&
                   (r_count < rac_pkg::COUNT_LIMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_sum_red   <= '0;
            r_sum_green <= '0;
            r_sum_blue  <= '0;
            r_count     <= '0;
        end else if (i_ctrl.pixel_en && w_inside) begin
            r_sum_red   <= r_sum_red + {24'd0, i_red};
            r_sum_green <= r_sum_green + {24'd0, i_green};
            r_sum_blue  <= r_sum_blue + {24'd0, i_blue};
            r_count     <= r_count + 25'd1;
        end
    end

    assign o_sum_red   = r_sum_red;
    assign o_sum_green = r_sum_green;
    assign o_sum_blue  = r_sum_blue;
    assign o_count     = r_count;

endmodule
`default_nettype wire

// ===== rtl/rac_div.sv =====
// Shared restoring divider: one quotient bit per cycle, eight-bit quotient.
`default_nettype none
module rac_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rac_pkg::t_div_req i_req,
    output rac_pkg::t_div_rsp      o_rsp
);

    logic [31:0] r_rem;
    logic [24:0] r_divisor;
    logic [7:0]  r_q;
    logic [2:0]  r_step;
    logic        r_busy;
    logic        r_done;
    logic [31:0] w_shift;
    logic [32:0] w_trial;
    logic        w_ge;

    // The quotient never exceeds eight bits: each sum is below count * 256
    always_comb begin
        w_shift = {7'd0, r_divisor} << r_step;
        w_trial = {1'b0, r_rem} - {1'b0, w_shift};
        w_ge    = !w_trial[32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            if (r_step == 3'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem     <= i_req.dividend;
            r_divisor <= i_req.divisor;
            r_q       <= '0;
            r_step    <= 3'd7;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= w_trial[31:0];
            end
            r_q    <= {r_q[6:0], w_ge};
            r_step <= r_step - 3'd1;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for region_average_colour: pixel frames against a mean colour predictor.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES    = 8;
    localparam int SETTLE_CYCLES   = 48;    // divider run plus margin
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int HOLD_OFF_CYCLES = 400;

    typedef struct {
        logic [11:0] col;
        logic [11:0] row;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic        frame_end;
    } t_pixel;

    typedef struct {
        logic [23:0] colour;
        logic [24:0] count;
    } t_frame_mean;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_psel;
    logic        i_penable;
    logic        i_pwrite;
    logic [3:0]  i_paddr;
    logic [31:0] i_pwdata;
    logic [31:0] o_prdata;
    logic        o_pready;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [47:0] i_s_axis_tdata;    // [11:0] x, [23:12] y, [31:24] blue, [39:32] green, [47:40] red
    logic        i_s_axis_tlast;    // frame_end
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [55:0] o_m_axis_tdata;    // [23:0] average_colour, [48:24] pixels_counted

    region_average_colour dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_psel          (i_psel),
        .i_penable       (i_penable),
        .i_pwrite        (i_pwrite),
        .i_paddr         (i_paddr),
        .i_pwdata        (i_pwdata),
        .o_prdata        (o_prdata),
        .o_pready        (o_pready),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Predictor state
    logic [11:0] reg_left, reg_right, reg_top, reg_bottom;
    logic [31:0] red_sum, green_sum, blue_sum;
    logic [24:0] pixel_total;
    t_frame_mean pending_means[$];

    int  mismatch_count = 0;
    int  pixels_sent    = 0;
    bit  src_idle       = 1'b1;
    bit  sink_idle      = 1'b1;
    int  hold_request   = 0;
    bit  run_started    = 1'b0;
    int  quiet_cycles   = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void accumulate_pixel(input t_pixel p);
        logic [11:0] right_lim;
        logic [11:0] bottom_lim;
        t_frame_mean m;
        right_lim  = (reg_right >= rac_pkg::SCREEN_WIDTH) ?
                     12'(rac_pkg::SCREEN_WIDTH - 1) : reg_right;
        bottom_lim = (reg_bottom >= rac_pkg::SCREEN_HEIGHT) ?
                     12'(rac_pkg::SCREEN_HEIGHT - 1) : reg_bottom;
        if (p.col >= reg_left && p.col < right_lim && p.row >= reg_top && p.row < bottom_lim &&
            pixel_total < rac_pkg::COUNT_LIMIT) begin
            red_sum     += p.red;
            green_sum   += p.green;
            blue_sum    += p.blue;
            pixel_total += 1'b1;
        end
        if (p.frame_end) begin
            m.colour = '0;
            if (pixel_total != 0)
                m.colour = {8'(red_sum / pixel_total), 8'(green_sum / pixel_total),
                            8'(blue_sum / pixel_total)};
            m.count = pixel_total;
            pending_means.push_back(m);
            red_sum     = '0;
            green_sum   = '0;
            blue_sum    = '0;
            pixel_total = '0;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH @%0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic write_region_reg(input logic [1:0] index, input logic [11:0] value);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {index, 2'b00};
        i_pwdata  <= {20'($urandom), value};
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        case (index)
            rac_pkg::REG_LEFT:   reg_left   = value;
            rac_pkg::REG_RIGHT:  reg_right  = value;
            rac_pkg::REG_TOP:    reg_top    = value;
            rac_pkg::REG_BOTTOM: reg_bottom = value;
            default: ;
        endcase
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
    endtask

    task automatic set_region(input logic [11:0] l, input logic [11:0] r,
                              input logic [11:0] t, input logic [11:0] b);
        write_region_reg(rac_pkg::REG_LEFT, l);
        write_region_reg(rac_pkg::REG_RIGHT, r);
        write_region_reg(rac_pkg::REG_TOP, t);
        write_region_reg(rac_pkg::REG_BOTTOM, b);
    endtask

    // Drop valid, wait for every mean, then let the block go quiet.
    task automatic settle_block();
        i_s_axis_tvalid <= 1'b0;
        while (pending_means.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_pixel(input t_pixel p);
        if (src_idle && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {p.red, p.green, p.blue, p.row, p.col};
        i_s_axis_tlast  <= p.frame_end;
        do @(posedge i_clk); while (!o_s_axis_tready);
        accumulate_pixel(p);
        pixels_sent++;
    endtask

    task automatic send_xy(input int col, input int row, input logic [7:0] b,
                           input logic [7:0] g, input logic [7:0] r, input bit last);
        t_pixel p;
        p.col = 12'(col);
        p.row = 12'(row);
        p.blue = b;
        p.green = g;
        p.red = r;
        p.frame_end = last;
        send_pixel(p);
    endtask

    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Mostly near the rectangle so edges and the inside get hit; the rest anywhere.
    function automatic t_pixel random_pixel();
        t_pixel p;
        int lo_x, hi_x, lo_y, hi_y;
        lo_x = (reg_left > 2) ? reg_left - 2 : 0;
        hi_x = ((reg_right > 1919) ? 1919 : int'(reg_right)) + 2;
        lo_y = (reg_top > 2) ? reg_top - 2 : 0;
        hi_y = ((reg_bottom > 1079) ? 1079 : int'(reg_bottom)) + 2;
        if ($urandom_range(0, 3) != 0) begin
            p.col = 12'($urandom_range(lo_x, hi_x));
            p.row = 12'($urandom_range(lo_y, hi_y));
        end else begin
            p.col = 12'($urandom);
            p.row = 12'($urandom);
        end
        p.blue = random_byte();
        p.green = random_byte();
        p.red = random_byte();
        p.frame_end = 1'b0;
        return p;
    endfunction

    task automatic send_random_frame(input int len);
        t_pixel p;
        for (int i = 0; i < len; i++) begin
            p = random_pixel();
            p.frame_end = (i == len - 1);
            send_pixel(p);
        end
    endtask

    task automatic pick_random_region();
        int l, t;
        l = $urandom_range(0, 1900);
        t = $urandom_range(0, 1070);
        case ($urandom_range(0, 5))
            0: set_region(12'(l), 12'(l + $urandom_range(1, 8)),
                          12'(t), 12'(t + $urandom_range(1, 8)));
            1: set_region(12'($urandom_range(1900, 1918)), 12'($urandom_range(1920, 4095)),
                          12'($urandom_range(1060, 1078)), 12'($urandom_range(1080, 4095)));
            2: begin
                l = $urandom_range(0, 4095);
                set_region(12'(l), 12'($urandom_range(0, l)),
                           12'($urandom), 12'($urandom));
            end
            3: set_region(12'd0, 12'd4095, 12'd0, 12'd4095);
            4: set_region(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
            default: set_region(12'(l), 12'(l + $urandom_range(1, 64)),
                                12'(t), 12'(t + $urandom_range(1, 64)));
        endcase
    endtask

    // Registers at reset describe an empty rectangle.
    task automatic test_empty_at_reset();
        send_xy(0, 0, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_xy(4095, 4095, 8'h00, 8'h00, 8'h00, 1'b1);
    endtask

    task automatic test_full_screen_edges();
        settle_block();
        set_region(12'd0, 12'd4095, 12'd0, 12'd4095);
        send_xy(0, 0, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_xy(1918, 1078, 8'h00, 8'h00, 8'h00, 1'b0);
        send_xy(1365, 682, 8'hAA, 8'h55, 8'h0F, 1'b0);
        send_xy(1919, 0, 8'h11, 8'h22, 8'h33, 1'b0);
        send_xy(0, 1079, 8'h44, 8'h55, 8'h66, 1'b0);
        send_xy(2730, 2730, 8'h77, 8'h88, 8'h99, 1'b0);
        send_xy(4095, 4095, 8'hFF, 8'h00, 8'hFF, 1'b1);
        // single pixel frame: mean equals the pixel
        send_xy(100, 200, 8'h12, 8'h34, 8'h56, 1'b1);
    endtask

    task automatic test_clamped_bounds();
        settle_block();
        set_region(12'd1918, 12'd1920, 12'd1078, 12'd1080);
        send_xy(1918, 1078, 8'h80, 8'h40, 8'h20, 1'b0);
        send_xy(1919, 1078, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_xy(1918, 1079, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_xy(1917, 1078, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_xy(1918, 1077, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_xy(1918, 1078, 8'h01, 8'h03, 8'h07, 1'b1);
    endtask

    task automatic test_empty_regions();
        settle_block();
        set_region(12'd500, 12'd500, 12'd0, 12'd4095);
        send_xy(500, 10, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_xy(499, 10, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        settle_block();
        set_region(12'd0, 12'd4095, 12'd700, 12'd600);
        send_xy(10, 650, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_xy(10, 700, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    endtask

    task automatic test_random_frames(input int item_goal, input bit with_idle);
        int goal_end;
        int len;
        goal_end  = pixels_sent + item_goal;
        src_idle  = with_idle;
        sink_idle = with_idle;
        while (pixels_sent < goal_end) begin
            settle_block();
            pick_random_region();
            repeat ($urandom_range(3, 8)) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 16);
                send_random_frame(len);
            end
        end
    endtask

    // Hold the result side while short frames keep coming, so the input stalls.
    task automatic test_output_backpressure();
        settle_block();
        set_region(12'd10, 12'd14, 12'd20, 12'd24);
        src_idle = 1'b0;
        hold_request = HOLD_OFF_CYCLES;
        repeat (6) send_random_frame($urandom_range(2, 5));
        src_idle = 1'b1;
    endtask

    initial begin : main_sequence
        i_rst_n         = 1'b0;
        i_psel          = 1'b0;
        i_penable       = 1'b0;
        i_pwrite        = 1'b0;
        i_paddr         = '0;
        i_pwdata        = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tlast  = 1'b0;
        reg_left = '0; reg_right = '0; reg_top = '0; reg_bottom = '0;
        red_sum = '0; green_sum = '0; blue_sum = '0; pixel_total = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_started = 1'b1;

        test_empty_at_reset();
        test_full_screen_edges();
        test_clamped_bounds();
        test_empty_regions();
        test_random_frames(420, 1'b1);
        test_output_backpressure();
        test_random_frames(120, 1'b0);

        settle_block();
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin : result_sink
        i_m_axis_tready = 1'b0;
        forever begin
            if (hold_request != 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (hold_request) @(posedge i_clk);
                hold_request = 0;
            end else if (sink_idle && $urandom_range(0, 5) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_frame_mean want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_means.size() == 0) begin
                report_mismatch("result with none pending", 32'(o_m_axis_tdata[48:0]), 32'd0);
            end else begin
                want = pending_means.pop_front();
                if (o_m_axis_tdata[23:0] !== want.colour)
                    report_mismatch("average_colour", 32'(o_m_axis_tdata[23:0]),
                                    32'(want.colour));
                if (o_m_axis_tdata[48:24] !== want.count)
                    report_mismatch("pixels_counted", 32'(o_m_axis_tdata[48:24]),
                                    32'(want.count));
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (run_started) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
                (i_psel && i_penable))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("simulation failed");
                $finish;
            end else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
`default_nettype wire
